// ===== rtl/brmm_pkg.sv =====
// Package for the battery running median monitor.
// Holds the widths, window size, codes and the cell control type.
// No dependencies.
`default_nettype none

package brmm_pkg;

  // Window length and the widths that follow from it.
  localparam int unsigned WINDOW = 10;
  localparam int unsigned AGE_W  = $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW);

  // Field and register widths.
  localparam int unsigned SUM_W   = 14;
  localparam int unsigned GAIN_W  = 17;
  localparam int unsigned MV_W    = 14;
  localparam int unsigned PROD_W  = SUM_W + GAIN_W;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned SCL_W   = PROD_W - FRAC_W;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STAT_W  = 2;

  // Constants of the scaling and status decisions.
  localparam logic [MV_W-1:0]   MV_MAX     = 14'd16383;
  localparam logic [MV_W-1:0]   ABSENT_MV  = 14'd2000;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 17'd27520;
  localparam logic [MV_W-1:0]   LOW_RST    = 14'd3300;
  localparam logic [AGE_W-1:0]  AGE_OLDEST = AGE_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0]  PASS_LAST  = CNT_W'(WINDOW - 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN      = 2'd0,
    REG_LOW_LIMIT = 2'd1
  } cfg_reg_e;

  // Battery status codes.
  typedef enum logic [STAT_W-1:0] {
    BATT_ABSENT = 2'd0,
    BATT_LOW    = 2'd1,
    BATT_OK     = 2'd2
  } batt_status_e;

  // Operations that the cell chain performs.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PRIME,
    CELL_INSERT,
    CELL_SORT
  } cell_op_e;

  // Control handed to each cell.
  typedef struct packed {
    cell_op_e op;
    logic     pair_lo;   // this cell is the lower member of a compare pair
    logic     pair_hi;   // this cell is the upper member of a compare pair
  } cell_ctrl_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS,
    ST_SORT,
    ST_DONE
  } brmm_state_e;

endpackage : brmm_pkg

`default_nettype wire

// ===== rtl/battery_running_median_monitor.sv =====
// Steps per reading: the scaler registers the product, the scaled reading is
// loaded into the chain, WINDOW odd-even compare passes run along the cell
// chain, and the result is registered when the output register is free.
// A new reading is taken only after the result of the last one is loaded.
// Reset (asynchronous, active low) empties the window and restores the
// register defaults; the first reading afterwards fills every cell.
`default_nettype none

module battery_running_median_monitor import brmm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [SUM_W-1:0]     sample_sum_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [MV_W-1:0]      median_mv_o,
  output logic      [STAT_W-1:0]    battery_status_o
);

  brmm_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              primed_q;
  logic [GAIN_W-1:0] gain_q;
  logic [MV_W-1:0]   low_limit_q;
  logic              out_valid_q;
  logic [MV_W-1:0]   median_q;
  batt_status_e      status_q;

  logic              in_acc;
  logic              out_load;
  cell_op_e          chain_op;
  logic              odd_pass;
  logic [MV_W-1:0]   new_mv;
  logic [MV_W-1:0]   med;
  logic [MV_W:0]     mid_sum;
  batt_status_e      status;

  logic [MV_W-1:0]   cell_mv  [WINDOW];
  logic [AGE_W-1:0]  cell_age [WINDOW];
  cell_ctrl_t        cell_ctrl [WINDOW];

  assign in_acc = in_valid_i && !in_stall_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= GAIN_RST;
      low_limit_q <= LOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN:      gain_q      <= cfg_wdata_i[GAIN_W-1:0];
        REG_LOW_LIMIT: low_limit_q <= cfg_wdata_i[MV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Scaling of the incoming reading.
  brmm_scale u_scale (
    .clk_i        (clk_i),
    .load_i       (in_acc),
    .sample_sum_i (sample_sum_i),
    .gain_i       (gain_q),
    .mv_o         (new_mv)
  );

  // Next state of the controller.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_INS;
        end
      end
      ST_INS: begin
        state_d = ST_SORT;
        cnt_d   = '0;
      end
      ST_SORT: begin
        if (cnt_q == PASS_LAST) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_stall_o = 1'b1;
    chain_op   = CELL_HOLD;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_INS: begin
        chain_op = primed_q ? CELL_INSERT : CELL_PRIME;
      end
      ST_SORT: begin
        chain_op = CELL_SORT;
      end
      ST_DONE: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      primed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == ST_INS) begin
        primed_q <= 1'b1;
      end
    end
  end

  // The cell chain; pass parity selects which neighbours pair up.
  assign odd_pass = cnt_q[0];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    localparam bit IdxOdd = (i % 2) != 0;
    localparam bit HasHi  = (i + 1) < WINDOW;
    localparam bit HasLo  = i > 0;
    localparam int unsigned LoIdx = HasLo ? i - 1 : i;
    localparam int unsigned HiIdx = HasHi ? i + 1 : i;

    assign cell_ctrl[i].op      = chain_op;
    assign cell_ctrl[i].pair_lo = HasHi && (IdxOdd == odd_pass);
    assign cell_ctrl[i].pair_hi = HasLo && (IdxOdd != odd_pass);

    brmm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl[i]),
      .new_mv_i (new_mv),
      .idx_i    (AGE_W'(i)),
      .lo_mv_i  (cell_mv[LoIdx]),
      .lo_age_i (cell_age[LoIdx]),
      .hi_mv_i  (cell_mv[HiIdx]),
      .hi_age_i (cell_age[HiIdx]),
      .mv_o     (cell_mv[i]),
      .age_o    (cell_age[i])
    );
  end

  // Median from the middle of the sorted chain, and the status.
  always_comb begin
    mid_sum = {1'b0, cell_mv[WINDOW/2]} + {1'b0, cell_mv[(WINDOW-1)/2]};
    if ((WINDOW % 2) != 0) begin
      med = cell_mv[WINDOW/2];
    end else begin
      med = mid_sum[MV_W:1];
    end
    if (med <= ABSENT_MV) begin
      status = BATT_ABSENT;
    end else if (med <= low_limit_q) begin
      status = BATT_LOW;
    end else begin
      status = BATT_OK;
    end
  end

  // Output register: holds the result beat until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      median_q <= med;
      status_q <= status;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_mv_o      = median_q;
  assign battery_status_o = status_q;

  // Checks on the chain ordering and the age bookkeeping.
  logic              chain_sorted;
  logic [WINDOW-1:0] ages_seen;

  always_comb begin
    chain_sorted = 1'b1;
    ages_seen    = '0;
    for (int k = 0; k < WINDOW; k++) begin
      ages_seen[cell_age[k]] = 1'b1;
      if ((k + 1 < WINDOW) && (cell_mv[k] > cell_mv[(k + 1) % WINDOW])) begin
        chain_sorted = 1'b0;
      end
    end
  end

  a_sorted_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> chain_sorted)
    else $error("cell chain not sorted after the sort passes");

  a_ages_permutation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (primed_q && (state_q == ST_IDLE)) |-> (ages_seen == {WINDOW{1'b1}}))
    else $error("cell ages are not a permutation of the window");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result beat raised outside the done state");

  a_pass_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SORT) |-> (cnt_q <= PASS_LAST))
    else $error("sort pass count out of range");

endmodule : battery_running_median_monitor

`default_nettype wire

// ===== rtl/brmm_scale.sv =====
// Reading scaler: registers the sum times the Q16 gain, then saturates
// and blanks readings below the absent threshold. Depends on brmm_pkg.
`default_nettype none

module brmm_scale import brmm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              load_i,
  input  wire logic [SUM_W-1:0]  sample_sum_i,
  input  wire logic [GAIN_W-1:0] gain_i,
  output logic      [MV_W-1:0]   mv_o
);

  logic [PROD_W-1:0] prod_q;
  logic [SCL_W-1:0]  scaled;
  logic [MV_W-1:0]   sat;

  // The product is captured on the accepted beat.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= PROD_W'(sample_sum_i) * PROD_W'(gain_i);
    end
  end

  // Drop the fraction, saturate, and treat small readings as no battery.
  always_comb begin
    scaled = prod_q[PROD_W-1:FRAC_W];
    if (scaled > SCL_W'(MV_MAX)) begin
      sat = MV_MAX;
    end else begin
      sat = scaled[MV_W-1:0];
    end
    if (sat < ABSENT_MV) begin
      mv_o = '0;
    end else begin
      mv_o = sat;
    end
  end

endmodule : brmm_scale

`default_nettype wire

// ===== rtl/brmm_cell.sv =====
// One cell of the sorted window chain: a reading and its age.
// Swaps with a neighbour during sort passes. Depends on brmm_pkg.
`default_nettype none

module brmm_cell import brmm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic [MV_W-1:0]  new_mv_i,
  input  wire logic [AGE_W-1:0] idx_i,
  input  wire logic [MV_W-1:0]  lo_mv_i,
  input  wire logic [AGE_W-1:0] lo_age_i,
  input  wire logic [MV_W-1:0]  hi_mv_i,
  input  wire logic [AGE_W-1:0] hi_age_i,
  output logic      [MV_W-1:0]  mv_o,
  output logic      [AGE_W-1:0] age_o
);

  logic [MV_W-1:0]  mv_q, mv_d;
  logic [AGE_W-1:0] age_q, age_d;

  // Next value of the cell for each chain operation.
  always_comb begin
    mv_d  = mv_q;
    age_d = age_q;
    case (ctrl_i.op)
      CELL_PRIME: begin
        mv_d  = new_mv_i;
        age_d = idx_i;
      end
      CELL_INSERT: begin
        if (age_q == AGE_OLDEST) begin
          mv_d  = new_mv_i;
          age_d = '0;
        end else begin
          age_d = age_q + AGE_W'(1);
        end
      end
      CELL_SORT: begin
        if (ctrl_i.pair_lo && (mv_q > hi_mv_i)) begin
          mv_d  = hi_mv_i;
          age_d = hi_age_i;
        end else if (ctrl_i.pair_hi && (lo_mv_i > mv_q)) begin
          mv_d  = lo_mv_i;
          age_d = lo_age_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q  <= '0;
      age_q <= '0;
    end else begin
      mv_q  <= mv_d;
      age_q <= age_d;
    end
  end

  assign mv_o  = mv_q;
  assign age_o = age_q;

endmodule : brmm_cell

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the battery running median monitor.
// Drives readings and register writes, predicts each median and status beat.
// Depends on brmm_pkg and battery_running_median_monitor from the rtl folder.
`timescale 1ns / 100ps

module tb_top import brmm_pkg::*; ();

  // Register indexes that the block does not implement; writes to them are dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Settling wait after the drain, receiver hold-off length and print cap.
  localparam int unsigned SETTLE_CYCLES = WINDOW + 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PRINT_CAP     = 100;

  // One expected result beat.
  typedef struct packed {
    logic [MV_W-1:0] median;
    batt_status_e    status;
  } median_beat_t;

  // Scoreboard: keeps its own window and registers, and queues the expected medians.
  class median_scoreboard;
    logic [GAIN_W-1:0] gain;
    logic [MV_W-1:0]   low_limit;
    logic [MV_W-1:0]   readings[WINDOW];
    int unsigned       slot;
    bit                primed;
    median_beat_t      expected_q[$];
    int unsigned       errors;

    function new();
      gain      = GAIN_RST;
      low_limit = LOW_RST;
      foreach (readings[i]) readings[i] = '0;
      slot      = 0;
      primed    = 1'b0;
      errors    = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // A register write seen at the port; values are cut to the register width.
    function void note_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_GAIN:      gain = data[GAIN_W-1:0];
        REG_LOW_LIMIT: low_limit = data[MV_W-1:0];
        default: ;
      endcase
    endfunction

    // Sum times gain, Q16, saturated, with readings under the absent level forced to zero.
    function logic [MV_W-1:0] to_millivolts(logic [SUM_W-1:0] sum);
      logic [PROD_W-1:0] prod;
      logic [SCL_W-1:0]  scaled;
      prod   = PROD_W'(sum) * PROD_W'(gain);
      scaled = SCL_W'(prod >> FRAC_W);
      if (scaled > SCL_W'(MV_MAX)) scaled = SCL_W'(MV_MAX);
      if (scaled < SCL_W'(ABSENT_MV)) scaled = '0;
      return scaled[MV_W-1:0];
    endfunction

    // Median of the window; the floored mean of the middle pair for an even length.
    function logic [MV_W-1:0] window_median();
      logic [MV_W-1:0] ordered[WINDOW];
      logic [MV_W-1:0] v;
      logic [MV_W:0]   pair;
      int              j;
      for (int i = 0; i < WINDOW; i++) begin
        v = readings[i];
        j = i;
        while (j > 0 && ordered[j-1] > v) begin
          ordered[j] = ordered[j-1];
          j--;
        end
        ordered[j] = v;
      end
      if (WINDOW % 2 != 0) return ordered[WINDOW/2];
      pair = {1'b0, ordered[WINDOW/2-1]} + {1'b0, ordered[WINDOW/2]};
      return pair[MV_W:1];
    endfunction

    // An accepted reading beat: update the window and queue the expected result.
    function void note_reading(logic [SUM_W-1:0] sum);
      logic [MV_W-1:0] mv;
      median_beat_t    beat;
      mv = to_millivolts(sum);
      if (!primed) begin
        // The first reading after reset fills the whole window.
        foreach (readings[i]) readings[i] = mv;
        slot   = 0;
        primed = 1'b1;
      end else begin
        readings[slot] = mv;
        slot = (slot + 1 == WINDOW) ? 0 : slot + 1;
      end
      beat.median = window_median();
      if (beat.median <= ABSENT_MV) beat.status = BATT_ABSENT;
      else if (beat.median <= low_limit) beat.status = BATT_LOW;
      else beat.status = BATT_OK;
      expected_q.push_back(beat);
    endfunction

    task report_mismatch(string msg);
      if (errors < PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    // An accepted result beat, compared with the oldest expectation.
    task check_result(logic [MV_W-1:0] median, logic [STAT_W-1:0] status);
      median_beat_t exp_beat;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected (median %0d)", median));
        return;
      end
      exp_beat = expected_q.pop_front();
      if (median !== exp_beat.median)
        report_mismatch($sformatf("median_mv %0d, expected %0d", median, exp_beat.median));
      if (status !== exp_beat.status)
        report_mismatch($sformatf("battery_status %0d, expected %0d", status, exp_beat.status));
    endtask
  endclass

  // Block ports.
  logic                 clk_i;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i    = '0;
  logic [CFG_W-1:0]     cfg_wdata_i  = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [SUM_W-1:0]     sample_sum_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [MV_W-1:0]      median_mv_o;
  logic [STAT_W-1:0]    battery_status_o;

  // Idling controls shared with the receiver process.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  logic [SUM_W-1:0] last_sum  = '0;

  median_scoreboard sb = new();

  battery_running_median_monitor i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_sum_i     (sample_sum_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .median_mv_o      (median_mv_o),
    .battery_status_o (battery_status_o)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit, well above the slowest correct run.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Monitor: register writes, accepted readings and accepted results, all sampled at the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.note_register(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_o) sb.note_reading(sample_sum_i);
      if (out_valid_o && !out_stall_i) sb.check_result(median_mv_o, battery_status_o);
    end
  end

  // Receiver: random stalls, and on request one long hold-off counted here.
  initial begin : receiver_stall
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offer one reading beat, after random idle cycles, and wait until it is taken.
  task send_reading(input logic [SUM_W-1:0] sum);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    sample_sum_i <= sum;
    last_sum      = sum;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Wait until every expected result has come and the chain has gone quiet.
  task wait_for_drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write beat.
  task write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random reading: sums spread over the whole field or up to 10230, sums that land
  // near the absent level or the low limit, the field's extremes, or a repeat of the last one.
  function logic [SUM_W-1:0] pick_sum();
    int unsigned mode;
    longint      target;
    longint      sum;
    mode = $urandom_range(99);
    if (mode < 30) begin
      sum = $urandom_range(16383);
    end else if (mode < 45) begin
      sum = $urandom_range(10230);
    end else if (mode < 85 && sb.gain != 0) begin
      target = $urandom_range(1) ? longint'(ABSENT_MV) : longint'(sb.low_limit);
      target = target + $urandom_range(8) - 4;
      if (target < 0) target = 0;
      sum = (target * 65536 + $urandom_range(1) * (sb.gain - 1)) / sb.gain;
      if (sum > 16383) sum = 16383;
    end else if (mode < 93) begin
      sum = last_sum;
    end else begin
      case ($urandom_range(2))
        0: sum = 0;
        1: sum = 10230;
        default: sum = 16383;
      endcase
    end
    return SUM_W'(sum);
  endfunction

  // Main sequence.
  initial begin : main_seq
    logic [CFG_W-1:0] gain_plan[8];
    logic [CFG_W-1:0] low_plan[8];
    int unsigned      idle_send[4];
    int unsigned      idle_recv[4];
    int unsigned      n_items;

    idle_send = '{0, 60, 0, 26};
    idle_recv = '{0, 0, 60, 26};
    gain_plan = '{GAIN_RST, 17'h1FFFF, CFG_W'($urandom), 17'd65536,
                  17'd0, CFG_W'($urandom_range(60000, 10000)), GAIN_RST, 17'd20000};
    low_plan  = '{LOW_RST, 17'h1FFFF, 17'd1999, CFG_W'($urandom),
                  17'd0, CFG_W'($urandom_range(6000, 2001)), 17'd2500, 17'd5000};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: first reading fills the window, then field extremes and the
    // sums either side of the absent level and the low limit at reset gain.
    send_reading(14'd10230);
    send_reading(14'd0);
    send_reading(14'd16383);
    send_reading(14'd4762);
    send_reading(14'd4763);
    send_reading(14'd4764);
    send_reading(14'd7858);
    send_reading(14'd7859);
    send_reading(14'd7860);
    send_reading(14'd1);
    send_reading(14'd8191);
    send_reading(14'd8192);
    wait_for_drain();

    // Largest gain saturates; an oversized low limit is cut to its width;
    // writes to unused indexes must change nothing.
    write_register(REG_GAIN, 17'h1FFFF);
    write_register(REG_LOW_LIMIT, 17'h1FFFF);
    write_register(REG_SPARE_A, CFG_W'($urandom));
    write_register(REG_SPARE_B, CFG_W'($urandom));
    send_reading(14'd16383);
    send_reading(14'd10230);
    send_reading(14'd100);
    send_reading(14'd5);
    wait_for_drain();

    // Zero gain, then a low limit under the absent level.
    write_register(REG_GAIN, 17'd0);
    send_reading(14'd16383);
    send_reading(14'd3);
    wait_for_drain();
    write_register(REG_GAIN, GAIN_RST);
    write_register(REG_LOW_LIMIT, 17'd1999);
    send_reading(14'd4763);
    send_reading(14'd4800);
    send_reading(14'd7859);
    send_reading(14'd9000);
    wait_for_drain();

    // Random phases, each with its own register setting and idling pattern.
    for (int p = 0; p < 8; p++) begin
      write_register(REG_GAIN, gain_plan[p]);
      write_register(REG_LOW_LIMIT, low_plan[p]);
      send_idle_pct  = idle_send[p % 4];
      recv_stall_pct = idle_recv[p % 4];
      // A long receiver hold-off while the sender keeps offering beats.
      if (p == 4) hold_requests++;
      n_items = (gain_plan[p] == 0) ? 30 : 240;
      repeat (n_items) send_reading(pick_sum());
      wait_for_drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule : tb_top

// ===== sim.f =====
rtl/brmm_pkg.sv
rtl/brmm_scale.sv
rtl/brmm_cell.sv
rtl/battery_running_median_monitor.sv
dv/tb_top.sv
